// File: rtl/imh_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the indexed min-heap unit.
package imh_pkg;
   // table depth: vertex numbers and heap slots both span 0..CAPACITY-1
   localparam int CAPACITY = 1024;

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_POP    = 2'd1;
   localparam logic [1:0] REQ_DEC    = 2'd2;
   localparam logic [1:0] REQ_DELETE = 2'd3;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_ABSENT  = 2'd3;

   localparam logic signed [31:0] DELETE_WEIGHT = -32'sd1000;

   // Compare-unit request: which relation decides a move.
   typedef enum logic [1:0] {
      CMP_GT,   // a > b
      CMP_GE,   // a >= b
      CMP_LT    // a < b
   } cmp_mode_type;
endpackage

// File: rtl/indexed_min_heap_unit.sv
`timescale 1ns / 1ps
// Indexed min-heap unit: top level with sequencer and storage.
//
// Binary min-heap of vertex numbers keyed by a signed 32-bit weight held per
// vertex, with a slot map so any present vertex can be located. One request
// word (insert, pop minimum, decrease weight, delete) yields one response
// word. Requests are served one at a time; req_tready is low while a request
// is in progress. Storage is four single-port RAMs (slot->vertex,
// vertex->slot, vertex->weight, presence); each sift level walks the first
// three and one shared comparator. Sift up moves one level per swap and
// ends on a last compare, with none at the root; sift down checks the
// children of each level it moves and ends on a last check. Around the
// sifts the sequencer takes the word, decodes it, writes an insert or pops
// the root, and loads the response. The worst case is a delete of the
// deepest vertex: 10 levels up, then a pop and 9 levels down. Presence bits
// live in a RAM that is cleared by a pass over every vertex after reset,
// during which req_tready stays low. The response sits in an output register
// and is held until taken; the next request may be accepted meanwhile.
module indexed_min_heap_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // req_type[1:0], vertex[11:2], weight[43:12]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // out_vertex[9:0], out_weight[41:10],
                                    // status[43:42], entry_count_out[54:44]
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data  // capacity_limit
);
   localparam int CAPACITY = imh_pkg::CAPACITY;
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = AW + 1;

   // sequencer states
   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_DECODE = 5'd1;
   localparam logic [4:0] S_INS0   = 5'd2;
   localparam logic [4:0] S_UP_RD  = 5'd3;   // read vertex at pos and parent
   localparam logic [4:0] S_UP_W1  = 5'd4;
   localparam logic [4:0] S_UP_W2  = 5'd5;
   localparam logic [4:0] S_UP_W3  = 5'd6;
   localparam logic [4:0] S_UP_CMP = 5'd7;
   localparam logic [4:0] S_SWP1   = 5'd8;
   localparam logic [4:0] S_SWP2   = 5'd9;
   localparam logic [4:0] S_SWP3   = 5'd10;
   localparam logic [4:0] S_POP0   = 5'd11;
   localparam logic [4:0] S_POP1   = 5'd12;
   localparam logic [4:0] S_POP2   = 5'd13;
   localparam logic [4:0] S_DN_RD  = 5'd14;
   localparam logic [4:0] S_DN_W1  = 5'd15;
   localparam logic [4:0] S_DN_W2  = 5'd16;
   localparam logic [4:0] S_DN_CMP = 5'd17;
   localparam logic [4:0] S_RESP   = 5'd18;
   localparam logic [4:0] S_DEC0   = 5'd19;
   localparam logic [4:0] S_DEC1   = 5'd20;
   localparam logic [4:0] S_DN_W0  = 5'd21;
   localparam logic [4:0] S_POPW   = 5'd22;
   localparam logic [4:0] S_CLEAR  = 5'd23;  // presence clearing pass

   // after a swap: continue up or down
   localparam logic UP = 1'b0;
   localparam logic DN = 1'b1;

   // sift-up rule
   localparam logic [1:0] UP_STRICT = 2'd0;  // past a strictly larger parent
   localparam logic [1:0] UP_GE     = 2'd1;  // past a parent >= the weight
   localparam logic [1:0] UP_FORCED = 2'd2;  // always to the root

   logic [4:0]  state_ff, state_in;
   logic [10:0] limit_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] clr_ff, clr_in;

   logic [1:0]  rq_ff, rq_in;
   logic [9:0]  rv_ff, rv_in;
   logic signed [31:0] rw_ff, rw_in;
   logic [1:0]  mode_ff, mode_in;    // sift-up rule
   logic        dir_ff, dir_in;
   logic [AW-1:0] pos_ff, pos_in, oth_ff, oth_in;
   logic [AW-1:0] va_ff, va_in, vb_ff, vb_in;
   logic signed [31:0] wa_ff, wa_in, wb_ff, wb_in;
   logic [2:0]  sub_ff, sub_in;      // child step: 0 left, 1 right
   logic [9:0]  ov_ff, ov_in;
   logic        rsp_v_ff, rsp_v_in;
   logic [55:0] rsp_d_ff, rsp_d_in;
   logic [1:0]  st_ff, st_in;

   // RAM ports
   logic          hs_we, sv_we, ws_we, pr_we;
   logic [AW-1:0] hs_a, hs_wd, sv_a, sv_wd, ws_a, pr_a;
   logic [31:0]   ws_wd;
   logic [AW-1:0] hs_rd, sv_rd;
   logic [31:0]   ws_rd;
   logic          pr_wd, pr_rd;

   imh_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_heap (
      .clock, .wr_en(hs_we), .addr(hs_a), .wr_data(hs_wd), .rd_data(hs_rd));
   imh_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_slot (
      .clock, .wr_en(sv_we), .addr(sv_a), .wr_data(sv_wd), .rd_data(sv_rd));
   imh_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_wt (
      .clock, .wr_en(ws_we), .addr(ws_a), .wr_data(ws_wd), .rd_data(ws_rd));
   imh_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_pres (
      .clock, .wr_en(pr_we), .addr(pr_a), .wr_data(pr_wd), .rd_data(pr_rd));

   imh_pkg::cmp_mode_type cmode;
   logic signed [31:0] ca, cb;
   logic chit;
   imh_cmp u_cmp (.mode(cmode), .a(ca), .b(cb), .hit(chit));

   logic [1:0]  in_rq;
   logic [9:0]  in_v;
   logic [CW-1:0] lim;
   logic [CW:0] lchild;
   logic v_ok;

   assign in_rq = req_tdata[1:0];
   assign in_v  = req_tdata[11:2];
   assign lim   = ({1'b0, limit_ff} > 12'(CAPACITY)) ? CW'(CAPACITY) : CW'(limit_ff);
   assign v_ok  = {22'd0, rv_ff} < CAPACITY;
   assign lchild = {pos_ff, 1'b1} + (CW+1)'(sub_ff[0]);

   // a waiting response does not hold off the next request
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_d_ff;

   always_comb begin
      state_in = state_ff; count_in = count_ff; clr_in = clr_ff;
      rq_in = rq_ff; rv_in = rv_ff; rw_in = rw_ff; mode_in = mode_ff;
      dir_in = dir_ff; pos_in = pos_ff; oth_in = oth_ff; va_in = va_ff;
      vb_in = vb_ff; wa_in = wa_ff; wb_in = wb_ff; sub_in = sub_ff;
      ov_in = ov_ff; st_in = st_ff; rsp_v_in = rsp_v_ff; rsp_d_in = rsp_d_ff;
      hs_we = 1'b0; sv_we = 1'b0; ws_we = 1'b0; pr_we = 1'b0;
      hs_a = pos_ff; hs_wd = va_ff; sv_a = rv_ff[AW-1:0]; sv_wd = pos_ff;
      ws_a = rv_ff[AW-1:0]; ws_wd = rw_ff;
      pr_a = rv_ff[AW-1:0]; pr_wd = 1'b0;
      cmode = imh_pkg::CMP_GT; ca = wa_ff; cb = wb_ff;
      if (rsp_v_ff && rsp_tready) rsp_v_in = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            pr_we = 1'b1; pr_a = clr_ff; pr_wd = 1'b0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(CAPACITY - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            pr_a = in_v[AW-1:0];    // presence ready in decode
            if (req_tvalid && req_tready) begin
               rq_in = in_rq; rv_in = in_v; rw_in = req_tdata[43:12];
               st_in = imh_pkg::ST_DONE; ov_in = '0;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            sv_a = rv_ff[AW-1:0];   // slot lookup for decrease/delete
            ws_a = rv_ff[AW-1:0];
            if (rq_ff == imh_pkg::REQ_POP) begin
               if (count_ff == '0) begin
                  st_in = imh_pkg::ST_EMPTY; state_in = S_RESP;
               end else begin
                  state_in = S_POP0;
               end
            end else if (!v_ok) begin
               st_in = imh_pkg::ST_ABSENT; state_in = S_RESP;
            end else if (rq_ff == imh_pkg::REQ_INSERT) begin
               if (count_ff >= lim) begin
                  st_in = imh_pkg::ST_FULL; state_in = S_RESP;
               end else if (pr_rd) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_INS0;
               end
            end else if (!pr_rd) begin
               st_in = imh_pkg::ST_ABSENT; state_in = S_RESP;
            end else begin
               state_in = S_DEC0;
            end
         end
         S_INS0: begin
            ws_we = 1'b1; ws_wd = rw_ff;
            hs_we = 1'b1; hs_a = count_ff[AW-1:0]; hs_wd = rv_ff[AW-1:0];
            sv_we = 1'b1; sv_wd = count_ff[AW-1:0];
            pr_we = 1'b1; pr_a = rv_ff[AW-1:0]; pr_wd = 1'b1;
            pos_in = count_ff[AW-1:0];
            count_in = count_ff + 1'b1;
            mode_in = UP_STRICT;
            state_in = S_UP_RD;
         end
         S_DEC0: begin
            // sv_rd = slot, ws_rd = old weight
            pos_in = sv_rd;
            if (rq_ff == imh_pkg::REQ_DELETE) begin
               ws_we = 1'b1; ws_wd = imh_pkg::DELETE_WEIGHT; mode_in = UP_FORCED;
               state_in = S_UP_RD;
            end else begin
               cmode = imh_pkg::CMP_GT; ca = rw_ff; cb = ws_rd;
               ws_we = 1'b1; ws_wd = rw_ff; mode_in = UP_GE;
               state_in = chit ? S_DN_RD : S_UP_RD;
            end
         end
         // ---- sift up: pos vs parent ----
         S_UP_RD: begin
            if (pos_ff == '0) begin
               state_in = (rq_ff == imh_pkg::REQ_DELETE) ? S_POP0 : S_RESP;
            end else begin
               oth_in = (pos_ff - 1'b1) >> 1;
               hs_a = pos_ff;
               state_in = S_UP_W1;
            end
         end
         S_UP_W1: begin
            hs_a = pos_ff; state_in = S_UP_W2;
         end
         S_UP_W2: begin
            va_in = hs_rd; ws_a = hs_rd; hs_a = oth_ff;   // va = vertex at pos
            state_in = S_UP_W3;
         end
         S_UP_W3: begin
            vb_in = hs_rd; ws_a = hs_rd; wa_in = ws_rd; state_in = S_UP_CMP;
         end
         S_UP_CMP: begin
            wb_in = ws_rd;
            cmode = (mode_ff == UP_STRICT) ? imh_pkg::CMP_GT : imh_pkg::CMP_GE;
            ca = ws_rd; cb = wa_ff;
            dir_in = UP;
            if (mode_ff == UP_FORCED || chit) state_in = S_SWP1;
            else state_in = (rq_ff == imh_pkg::REQ_DELETE) ? S_POP0 : S_RESP;
         end
         // ---- swap heap[pos] (va) and heap[oth] (vb) ----
         S_SWP1: begin
            hs_we = 1'b1; hs_a = pos_ff; hs_wd = vb_ff;
            state_in = S_SWP2;
         end
         S_SWP2: begin
            hs_we = 1'b1; hs_a = oth_ff; hs_wd = va_ff;
            sv_we = 1'b1; sv_a = va_ff; sv_wd = oth_ff;
            state_in = S_SWP3;
         end
         S_SWP3: begin
            sv_we = 1'b1; sv_a = vb_ff; sv_wd = pos_ff;
            pos_in = oth_ff;
            state_in = (dir_ff == UP) ? S_UP_RD : S_DN_RD;
         end
         // ---- pop root ----
         S_POP0: begin
            hs_a = '0; state_in = S_POPW;
         end
         S_POPW: begin
            ov_in = 10'(hs_rd); hs_a = AW'(count_ff - 1'b1);
            ws_a = hs_rd; state_in = S_POP1;
         end
         S_POP1: begin
            // hs_rd = last vertex, ws_rd = popped weight
            if (rq_ff == imh_pkg::REQ_POP) rw_in = ws_rd;
            else rw_in = '0;
            hs_we = 1'b1; hs_a = '0; hs_wd = hs_rd;
            sv_we = 1'b1; sv_a = hs_rd; sv_wd = '0;
            pr_we = 1'b1; pr_a = ov_ff[AW-1:0]; pr_wd = 1'b0;
            count_in = count_ff - 1'b1;
            pos_in = '0;
            state_in = S_POP2;
         end
         S_POP2: begin
            state_in = (count_ff == '0) ? S_RESP : S_DN_RD;
         end
         // ---- sift down: pos vs left then right child ----
         S_DN_RD: begin
            hs_a = pos_ff; sub_in = '0; state_in = S_DN_W0;
         end
         S_DN_W0: begin
            // best-so-far starts as pos
            ws_a = hs_rd; va_in = hs_rd; oth_in = pos_ff; state_in = S_DN_W1;
         end
         S_DN_W1: begin
            if (sub_ff == 3'd0) wa_in = ws_rd;
            if (lchild >= (CW+1)'(count_ff)) begin
               state_in = S_DN_CMP;
            end else begin
               hs_a = lchild[AW-1:0]; state_in = S_DN_W2;
            end
         end
         S_DN_W2: begin
            ws_a = hs_rd; vb_in = hs_rd; sub_in = {sub_ff[2:1], sub_ff[0]} | 3'b100;
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            // sub[2] set: child weight arriving now
            if (sub_ff[2]) begin
               cmode = imh_pkg::CMP_LT; ca = ws_rd; cb = wb_ff;
               if (oth_ff == pos_ff) cb = wa_ff;
               if (chit) begin
                  wb_in = ws_rd; oth_in = lchild[AW-1:0];
               end
            end
            if (sub_ff[0] == 1'b0) begin
               sub_in = 3'b001; state_in = S_DN_W1;
            end else if ((sub_ff[2] && chit) ? 1'b0 : (oth_ff == pos_ff)) begin
               state_in = S_RESP;
            end else begin
               // fetch chosen child vertex for swap
               hs_a = sub_ff[2] && chit ? lchild[AW-1:0] : oth_ff;
               state_in = S_DEC1;
            end
         end
         S_DEC1: begin
            vb_in = hs_rd; dir_in = DN;
            // swap: heap[pos]=vb, heap[oth]=va
            state_in = S_SWP1;
         end
         S_RESP: begin
            if (!rsp_v_ff) begin
               rsp_v_in = 1'b1;
               rsp_d_in = {1'b0, 11'(count_ff), st_ff,
                           (rq_ff == imh_pkg::REQ_POP && st_ff == imh_pkg::ST_DONE)
                              ? rw_ff : 32'sd0,
                           (st_ff == imh_pkg::ST_DONE) ? ov_ff : 10'd0};
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; limit_ff <= 11'd1024; count_ff <= '0;
         clr_ff <= '0; rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in;
         clr_ff <= clr_in; rsp_v_ff <= rsp_v_in;
         if (csr_wr_en) limit_ff <= csr_wr_data;
      end
      rq_ff <= rq_in; rv_ff <= rv_in; rw_ff <= rw_in; mode_ff <= mode_in;
      dir_ff <= dir_in; pos_ff <= pos_in; oth_ff <= oth_in; va_ff <= va_in;
      vb_ff <= vb_in; wa_ff <= wa_in; wb_ff <= wb_in; sub_ff <= sub_in;
      ov_ff <= ov_in; st_ff <= st_in; rsp_d_ff <= rsp_d_in;
   end

   // entry count never exceeds the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY)) else $error("entry count overflow");
   // a held response keeps its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && !rsp_tready |=> rsp_v_ff && $stable(rsp_d_ff))
      else $error("response changed while stalled");
   // a taken request always starts in decode
   a_one_at_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == S_DECODE)
      else $error("request accepted outside idle");
endmodule

// File: rtl/imh_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
module imh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/imh_cmp.sv
`timescale 1ns / 1ps
// Shared signed weight comparator used by every sift step.
module imh_cmp (
   input  imh_pkg::cmp_mode_type mode,
   input  logic signed [31:0]    a,
   input  logic signed [31:0]    b,
   output logic                  hit
);
   always_comb begin
      case (mode)
         imh_pkg::CMP_GT: hit = a > b;
         imh_pkg::CMP_GE: hit = a >= b;
         default:         hit = a < b;
      endcase
   end
endmodule

// File: verif/indexed_min_heap_checker.sv
`timescale 1ns / 1ps
// Checker for the indexed min-heap unit: heap predictor and response compare.
module indexed_min_heap_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data,
   output int          fail_count,
   output int          pending_count,
   output int          word_count
);
   localparam int SLOTS = 1024;

   typedef struct packed {
      logic [10:0]        count;
      logic [1:0]         status;
      logic signed [31:0] weight;
      logic [9:0]         vertex;
   } heap_answer_type;

   logic [9:0]         slot_vertex [SLOTS];
   logic [9:0]         vertex_slot [SLOTS];
   logic signed [31:0] vertex_weight [SLOTS];
   logic               vertex_in [SLOTS];
   int                 heap_size;
   int                 size_limit;
   heap_answer_type    answers_due [$];

   function automatic logic signed [31:0] key_at(int pos);
      return vertex_weight[slot_vertex[pos]];
   endfunction

   function automatic void exchange(int a, int b);
      logic [9:0] va, vb;
      va = slot_vertex[a];
      vb = slot_vertex[b];
      slot_vertex[a] = vb;
      slot_vertex[b] = va;
      vertex_slot[vb] = 10'(a);
      vertex_slot[va] = 10'(b);
   endfunction

   // rule 0: strictly larger parent, 1: parent >= child, 2: always to the root
   function automatic void bubble_up(int pos, int rule);
      int par;
      bit go;
      while (pos > 0) begin
         par = (pos - 1) / 2;
         if (rule == 0) go = key_at(par) > key_at(pos);
         else if (rule == 1) go = key_at(par) >= key_at(pos);
         else go = 1;
         if (!go) break;
         exchange(par, pos);
         pos = par;
      end
   endfunction

   function automatic void bubble_down(int pos);
      int l, r, m;
      forever begin
         l = 2 * pos + 1;
         r = l + 1;
         m = pos;
         if (l < heap_size && key_at(l) < key_at(m)) m = l;
         if (r < heap_size && key_at(r) < key_at(m)) m = r;
         if (m == pos) break;
         exchange(m, pos);
         pos = m;
      end
   endfunction

   function automatic logic [9:0] take_root();
      logic [9:0] v, tail;
      v = slot_vertex[0];
      tail = slot_vertex[heap_size - 1];
      slot_vertex[0] = tail;
      vertex_slot[tail] = '0;
      heap_size--;
      vertex_in[v] = 0;
      if (heap_size > 0) bubble_down(0);
      return v;
   endfunction

   function automatic heap_answer_type serve(logic [1:0] kind, logic [9:0] v,
                                             logic signed [31:0] w);
      heap_answer_type a;
      int pos;
      a = '0;
      if (kind == imh_pkg::REQ_POP) begin
         if (heap_size == 0) a.status = imh_pkg::ST_EMPTY;
         else begin
            a.vertex = take_root();
            a.weight = vertex_weight[a.vertex];
         end
      end else if (kind == imh_pkg::REQ_INSERT) begin
         if (heap_size >= size_limit) a.status = imh_pkg::ST_FULL;
         else if (!vertex_in[v]) begin
            vertex_weight[v] = w;
            slot_vertex[heap_size] = v;
            vertex_slot[v] = 10'(heap_size);
            vertex_in[v] = 1;
            heap_size++;
            bubble_up(heap_size - 1, 0);
         end
      end else if (!vertex_in[v]) a.status = imh_pkg::ST_ABSENT;
      else if (kind == imh_pkg::REQ_DEC) begin
         pos = int'(vertex_slot[v]);
         if (w > vertex_weight[v]) begin
            vertex_weight[v] = w;
            bubble_down(pos);
         end else begin
            vertex_weight[v] = w;
            bubble_up(pos, 1);
         end
      end else begin
         vertex_weight[v] = imh_pkg::DELETE_WEIGHT;
         bubble_up(int'(vertex_slot[v]), 2);
         a.vertex = take_root();
      end
      a.count = 11'(heap_size);
      return a;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      heap_answer_type want, got;
      if (reset) begin
         heap_size <= 0;
         size_limit <= SLOTS;
         fail_count <= 0;
         word_count <= 0;
         answers_due.delete();
         pending_count = 0;
         for (int i = 0; i < SLOTS; i++) vertex_in[i] = 0;
      end else begin
         if (csr_wr_en)
            size_limit = (csr_wr_data > SLOTS) ? SLOTS : int'(csr_wr_data);
         if (req_tvalid && req_tready)
            answers_due.push_back(serve(req_tdata[1:0], req_tdata[11:2],
                                        req_tdata[43:12]));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[54:0];
            word_count <= word_count + 1;
            if (answers_due.size() == 0) report("unexpected word", got, 0);
            else begin
               want = answers_due.pop_front();
               if (got.vertex !== want.vertex) report("vertex", got.vertex, want.vertex);
               if (got.weight !== want.weight) report("weight", got.weight, want.weight);
               if (got.status !== want.status) report("status", got.status, want.status);
               if (got.count !== want.count) report("count", got.count, want.count);
            end
         end
         pending_count = answers_due.size();
      end
   end
endmodule

// File: verif/indexed_min_heap_unit_test.sv
`timescale 1ns / 1ps
// Top of the indexed min-heap test: stimulus, idling and verdict.
module indexed_min_heap_unit_test;
   localparam int  CYCLE_LIMIT = 600000;

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [47:0] req_tdata;   // req_type[1:0], vertex[11:2], weight[43:12]
   logic        rsp_tvalid, rsp_tready;
   logic [55:0] rsp_tdata;   // out_vertex[9:0], out_weight[41:10], status, count
   logic        csr_wr_en;
   logic [10:0] csr_wr_data;
   int          fail_count, pending_count, word_count;
   int          cycle_count;
   int          sent;
   int          hold_off;     // cycles the receiver must keep stalling
   bit          stall_mode;

   indexed_min_heap_unit uut (.*);

   indexed_min_heap_checker check (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Cycle watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Receiver: own stall pattern, plus a long forced hold-off when asked.
   always @(negedge clock) begin
      if (reset) rsp_tready <= 0;
      else if (hold_off > 0) begin
         rsp_tready <= 0;
         hold_off <= hold_off - 1;
      end else if (stall_mode) rsp_tready <= ($urandom_range(0, 3) != 0);
      else rsp_tready <= 1;
      if (!reset && $urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
   end

   // One request word; waits for the handshake. Burst gaps on the sender side.
   task automatic send(logic [1:0] kind, logic [9:0] v, logic signed [31:0] w,
                       bit gaps = 1);
      req_tdata <= {4'b0, w, v, kind};
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      sent++;
      if (gaps && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (300) @(negedge clock);  // idle gap after the last response
   endtask

   task automatic set_limit(logic [10:0] lim);
      drain();
      csr_wr_en <= 1;
      csr_wr_data <= lim;
      @(negedge clock);
      csr_wr_en <= 0;
   endtask

   function automatic logic signed [31:0] rand_weight();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 20) - 10;       // many ties
         1: return 32'sh8000_0000 + $urandom_range(0, 3);
         2: return 32'sh7fff_ffff - $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   // Random phase on a vertex pool: mostly well-formed traffic.
   task automatic random_phase(int n, int pool);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 9);
         if (r < 4)
            send(imh_pkg::REQ_INSERT, 10'($urandom_range(0, pool - 1)), rand_weight());
         else if (r < 6) send(imh_pkg::REQ_POP, 10'($urandom), $urandom);
         else if (r < 8)
            send(imh_pkg::REQ_DEC, 10'($urandom_range(0, pool - 1)), rand_weight());
         else if (r < 9)
            send(imh_pkg::REQ_DELETE, 10'($urandom_range(0, pool - 1)), $urandom);
         else send(2'($urandom), 10'($urandom), $urandom);  // noise
      end
   endtask

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      csr_wr_en = 0;
      csr_wr_data = '0;
      hold_off = 0;
      stall_mode = 0;
      sent = 0;
      cycle_count = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: empty pop, absent vertex, extremes, ties, duplicate insert.
      send(imh_pkg::REQ_POP, 10'h3ff, 32'hffff_ffff);
      send(imh_pkg::REQ_DEC, 10'd5, 0);
      send(imh_pkg::REQ_DELETE, 10'd5, 0);
      send(imh_pkg::REQ_INSERT, 10'h3ff, 32'sh7fff_ffff);
      send(imh_pkg::REQ_INSERT, 10'd0, 32'sh8000_0000);
      send(imh_pkg::REQ_INSERT, 10'd7, 32'sd5);
      send(imh_pkg::REQ_INSERT, 10'd8, 32'sd5);
      send(imh_pkg::REQ_INSERT, 10'd7, 32'sd1);       // already present
      send(imh_pkg::REQ_DEC, 10'd8, 32'sd5);          // equal weight takes the sift-up path
      send(imh_pkg::REQ_DEC, 10'd0, 32'sh7fff_fffe);  // raise: sift down
      send(imh_pkg::REQ_DELETE, 10'd7, 0);
      send(imh_pkg::REQ_INSERT, 10'd9, -32'sd1000);
      send(imh_pkg::REQ_DELETE, 10'h3ff, 0);
      repeat (4) send(imh_pkg::REQ_POP, 10'd0, 0);

      // Small limits: full condition and limit of one.
      set_limit(11'd1);
      send(imh_pkg::REQ_INSERT, 10'd1, 32'sd3);
      send(imh_pkg::REQ_INSERT, 10'd2, 32'sd4);       // full
      send(imh_pkg::REQ_POP, 10'd0, 0);
      set_limit(11'd0);
      send(imh_pkg::REQ_INSERT, 10'd1, 32'sd3);       // limit zero refuses
      set_limit(11'd2047);                   // above capacity acts as capacity
      random_phase(100, 64);

      // Long receiver hold-off while the sender keeps offering.
      hold_off = 400;
      random_phase(30, 64);

      // Sender pause until all answers are in, then a small limit phase.
      set_limit(11'd12);
      random_phase(100, 32);
      set_limit(11'd1024);
      random_phase(200, 1024);
      drain();
      $display("sent %0d request words, checked %0d response words,",
               sent, word_count);
      $display("limits 0, 1, 12, 1024 and 2047, with stalls and hold-off");
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule

// File: indexed_min_heap_unit.f
rtl/imh_pkg.sv
rtl/imh_ram.sv
rtl/imh_cmp.sv
rtl/indexed_min_heap_unit.sv
verif/indexed_min_heap_checker.sv
verif/indexed_min_heap_unit_test.sv
